// File: hdl/sgd_pkg.sv
// sgd_pkg: widths, codes, handshake structs and the divide-by-three helper
// shared by the sobel gradient/direction core, its interfaces and root unit
// no dependencies
package sgd_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM3_W     = 10;
  localparam int LW_W       = 11;
  localparam int POS_W      = 10;
  localparam int GRAD_W     = 10;
  localparam int SQ_W       = 2 * GRAD_W;
  localparam int RAD_W      = 22;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int STEP_W     = 4;
  localparam int DIR_W      = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 11'd640;
  localparam logic [PIX_W-1:0] MAG_MAX          = 8'd255;

  // register index, taken from paddr word bit
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORIZ = 3'd0,
    DIR_DIAG  = 3'd1,
    DIR_VERT  = 3'd2,
    DIR_ANTI  = 3'd3,
    DIR_NONE  = 3'd4
  } dir_e;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

  // floor(sum / 3) for sum <= 765 via 683 / 2048
  function automatic logic [PIX_W-1:0] div3(input logic [SUM3_W-1:0] sum);
    logic [20:0] prod;
    prod = 21'(sum) * 21'(683);
    return prod[18:11];
  endfunction

endpackage

// File: hdl/sgd_pix_if.sv
// sgd_pix_if: valid/ready channel carrying one rgb pixel item
// depends on sgd_pkg for channel widths
interface sgd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [sgd_pkg::PIX_W-1:0] red;
  logic [sgd_pkg::PIX_W-1:0] green;
  logic [sgd_pkg::PIX_W-1:0] blue;
  logic                      start_of_frame;

  modport source (output valid, red, green, blue, start_of_frame, input ready);
  modport sink   (input valid, red, green, blue, start_of_frame, output ready);
endinterface

// File: hdl/sgd_res_if.sv
// sgd_res_if: valid/ready channel carrying one gradient result item
// depends on sgd_pkg for field widths
interface sgd_res_if;
  logic                      valid;
  logic                      ready;
  logic [sgd_pkg::PIX_W-1:0] magnitude;
  logic [sgd_pkg::DIR_W-1:0] direction;
  logic [sgd_pkg::PIX_W-1:0] frame_max;
  logic [sgd_pkg::POS_W-1:0] out_column;
  logic [sgd_pkg::POS_W-1:0] out_row;

  modport source (output valid, magnitude, direction, frame_max, out_column, out_row,
                  input ready);
  modport sink   (input valid, magnitude, direction, frame_max, out_column, out_row,
                  output ready);
endinterface

// File: hdl/sobel_gradient_direction_core.sv
// sobel gradient core: one item at a time; a pixel with no result goes back to
// idle after S_READ; a pixel with a result runs S_GRAD, the shared multiplier
// pass and the 11-step square root, then shows it and frees the input in S_DONE
// an unread result waits in the output register while the next pixel is accepted
// reset clears counters, window, running max and line_width (640); line memory
// contents stay undefined until written, no clearing pass
module sobel_gradient_direction_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sgd_pix_if.sink                            pix_i,
  sgd_res_if.source                          res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sgd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sgd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sgd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int CntW = $clog2(MAX_WIDTH + 1);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int PW   = sgd_pkg::PIX_W;
  localparam int GW   = sgd_pkg::GRAD_W;
  localparam int SW   = sgd_pkg::SQ_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_GRAD   = 3'd2;
  localparam logic [2:0] S_MUL_X  = 3'd3;
  localparam logic [2:0] S_MUL_Y  = 3'd4;
  localparam logic [2:0] S_MUL_XY = 3'd5;
  localparam logic [2:0] S_ROOT   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]                state_q, state_d;
  logic [sgd_pkg::LW_W-1:0]  line_width_q;
  logic [ColW-1:0]           col_q, col_d;
  logic [RowW-1:0]           row_q, row_d;
  logic [ColW-1:0]           item_col_q;
  logic [RowW-1:0]           item_row_q;
  logic [PW-1:0]             gray_q;
  logic [2*PW-1:0]           rd_q;
  logic [PW-1:0]             win_q [9];
  logic [GW-1:0]             ax_q, ay_q;
  logic                      same_q;
  logic [SW-1:0]             ax2_q, ay2_q, axy_q;
  logic [sgd_pkg::DIR_W-1:0] dir_q;
  logic [PW-1:0]             max_q;
  logic                      out_valid_q;
  logic [PW-1:0]             out_mag_q, out_max_q;
  logic [sgd_pkg::DIR_W-1:0] out_dir_q;
  logic [sgd_pkg::POS_W-1:0] out_col_q, out_row_q;

  // each entry holds {row above, two rows above}
  logic [2*PW-1:0]           line_mem [MAX_WIDTH];

  logic                      accept;
  logic                      cfg_wr;
  logic [CntW-1:0]           width_use;
  logic [ColW-1:0]           c0, c1;
  logic [RowW-1:0]           r0, r1;
  logic [CntW-1:0]           c_next;
  logic                      emit;
  logic [GW-1:0]             gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GW-1:0]             mul_a, mul_b;
  logic [SW-1:0]             prod;
  logic [SW:0]               energy, two_axy, two_ax2, diff;
  logic [SW+1:0]             sum_sq;
  sgd_pkg::dir_e             dir_c;
  logic                      load;
  logic [PW-1:0]             mag_c, max_c;
  logic [31:0]               pos_col, pos_row;
  sgd_pkg::root_req_t        root_req;
  sgd_pkg::root_rsp_t        root_rsp;

  function automatic logic [RowW-1:0] row_inc(input logic [RowW-1:0] r);
    if (32'(r) + 32'd1 >= 32'(MAX_HEIGHT)) begin
      return '0;
    end
    return r + RowW'(1);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sgd_pkg::REG_LINE_WIDTH) ?
                  sgd_pkg::APB_DATA_W'(line_width_q) : '0;

  always_comb begin
    if (line_width_q < sgd_pkg::LW_W'(3)) begin
      width_use = CntW'(3);
    end else if (32'(line_width_q) > 32'(MAX_WIDTH)) begin
      width_use = CntW'(MAX_WIDTH);
    end else begin
      width_use = CntW'(line_width_q);
    end
  end

  // position of the incoming pixel and counters after it
  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    c0 = pix_i.start_of_frame ? '0 : col_q;
    r0 = pix_i.start_of_frame ? '0 : row_q;
    if (CntW'(c0) >= width_use) begin
      c1 = '0;
      r1 = row_inc(r0);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    c_next = CntW'(c1) + CntW'(1);
    if (c_next >= width_use) begin
      col_d = '0;
      row_d = row_inc(r1);
    end else begin
      col_d = c_next[ColW-1:0];
      row_d = r1;
    end
  end

  assign emit = (32'(item_col_q) >= 32'd2) && (32'(item_row_q) >= 32'd2);

  // sobel sums, kept as positive and negative halves
  always_comb begin
    gx_pos = GW'(win_q[2]) + GW'({win_q[5], 1'b0}) + GW'(win_q[8]);
    gx_neg = GW'(win_q[0]) + GW'({win_q[3], 1'b0}) + GW'(win_q[6]);
    gy_pos = GW'(win_q[6]) + GW'({win_q[7], 1'b0}) + GW'(win_q[8]);
    gy_neg = GW'(win_q[0]) + GW'({win_q[1], 1'b0}) + GW'(win_q[2]);
  end

  // one multiplier shared over the S_MUL_X, S_MUL_Y and S_MUL_XY states
  always_comb begin
    unique case (state_q)
      S_MUL_X: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      S_MUL_Y: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      default: begin
        mul_a = ax_q;
        mul_b = ay_q;
      end
    endcase
    prod = SW'(mul_a) * SW'(mul_b);
  end

  // sector test: (ay+ax)^2 and (ay-ax)^2 rebuilt from ax^2 + ay^2 +- 2 ax ay
  always_comb begin
    energy  = (SW + 1)'(ax2_q) + (SW + 1)'(ay2_q);
    two_axy = {axy_q, 1'b0};
    two_ax2 = {ax2_q, 1'b0};
    sum_sq  = (SW + 2)'(energy) + (SW + 2)'(two_axy);
    diff    = energy - two_axy;
    if (ax_q == '0 && ay_q == '0) begin
      dir_c = sgd_pkg::DIR_NONE;
    end else if (sum_sq < (SW + 2)'(two_ax2)) begin
      dir_c = sgd_pkg::DIR_HORIZ;
    end else if (ay_q >= ax_q && diff >= two_ax2) begin
      dir_c = sgd_pkg::DIR_VERT;
    end else if (same_q) begin
      dir_c = sgd_pkg::DIR_DIAG;
    end else begin
      dir_c = sgd_pkg::DIR_ANTI;
    end
  end

  assign root_req.start    = (state_q == S_MUL_XY);
  assign root_req.radicand = sgd_pkg::RAD_W'(energy);

  sgd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (root_req),
    .rsp_o  (root_rsp)
  );

  always_comb begin
    load    = (state_q == S_DONE) && (!out_valid_q || res_o.ready);
    mag_c   = (root_rsp.root > sgd_pkg::ROOT_W'(sgd_pkg::MAG_MAX)) ?
              sgd_pkg::MAG_MAX : root_rsp.root[PW-1:0];
    max_c   = (mag_c > max_q) ? mag_c : max_q;
    pos_col = 32'(item_col_q) - 32'd2;
    pos_row = 32'(item_row_q) - 32'd2;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_READ;
      S_READ:   state_d = emit ? S_GRAD : S_IDLE;
      S_GRAD:   state_d = S_MUL_X;
      S_MUL_X:  state_d = S_MUL_Y;
      S_MUL_Y:  state_d = S_MUL_XY;
      S_MUL_XY: state_d = S_ROOT;
      S_ROOT:   if (root_rsp.done) state_d = S_DONE;
      S_DONE:   if (load) state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      line_width_q <= sgd_pkg::LINE_WIDTH_RESET;
      col_q        <= '0;
      row_q        <= '0;
      max_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr && paddr[2] == sgd_pkg::REG_LINE_WIDTH) begin
        line_width_q <= pwdata[sgd_pkg::LW_W-1:0];
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (pix_i.start_of_frame) begin
          max_q <= '0;
        end
      end
      if (state_q == S_READ) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= rd_q[PW-1:0];
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= rd_q[2*PW-1:PW];
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= gray_q;
      end
      if (load) begin
        max_q       <= max_c;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line memory: read on acceptance, written back in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[c1];
    end
    if (state_q == S_READ) begin
      line_mem[item_col_q] <= {gray_q, rd_q[2*PW-1:PW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_col_q <= c1;
      item_row_q <= r1;
      gray_q     <= sgd_pkg::div3(sgd_pkg::SUM3_W'(pix_i.red) +
                                  sgd_pkg::SUM3_W'(pix_i.green) +
                                  sgd_pkg::SUM3_W'(pix_i.blue));
    end
    if (state_q == S_GRAD) begin
      ax_q   <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
      ay_q   <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
      same_q <= (gx_pos > gx_neg) == (gy_pos > gy_neg);
    end
    if (state_q == S_MUL_X) begin
      ax2_q <= prod;
    end
    if (state_q == S_MUL_Y) begin
      ay2_q <= prod;
    end
    if (state_q == S_MUL_XY) begin
      axy_q <= prod;
    end
    if (state_q == S_ROOT) begin
      dir_q <= dir_c;
    end
    if (load) begin
      out_mag_q <= mag_c;
      out_max_q <= max_c;
      out_dir_q <= dir_q;
      out_col_q <= pos_col[sgd_pkg::POS_W-1:0];
      out_row_q <= pos_row[sgd_pkg::POS_W-1:0];
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.magnitude  = out_mag_q;
  assign res_o.direction  = out_dir_q;
  assign res_o.frame_max  = out_max_q;
  assign res_o.out_column = out_col_q;
  assign res_o.out_row    = out_row_q;

  // one pixel in flight: input closes right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !pix_i.ready)
    else $error("pixel accepted while previous item still in flight");

  // a result appears only out of the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result valid raised outside finishing state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_max >= res_o.magnitude)
    else $error("frame maximum below reported magnitude");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.direction == sgd_pkg::DIR_NONE |-> res_o.magnitude == '0)
    else $error("no-gradient sector with nonzero magnitude");

endmodule

// File: hdl/sgd_isqrt.sv
// sgd_isqrt: digit-by-digit floor square root, two radicand bits per cycle
// depends on sgd_pkg for widths and the request/response structs
module sgd_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sgd_pkg::root_req_t req_i,
  output sgd_pkg::root_rsp_t rsp_o
);

  localparam int RemW = sgd_pkg::ROOT_W + 1;
  localparam int ShW  = RemW + 2;

  logic                        busy_q;
  logic [sgd_pkg::STEP_W-1:0]  step_q;
  logic [sgd_pkg::RAD_W-1:0]   rad_q;
  logic [RemW-1:0]             rem_q;
  logic [sgd_pkg::ROOT_W-1:0]  root_q;

  logic [ShW-1:0]              rem_sh;
  logic [ShW-1:0]              trial;
  logic                        geq;
  logic [RemW-1:0]             rem_d;
  logic [sgd_pkg::ROOT_W-1:0]  root_d;
  logic                        last;

  always_comb begin
    rem_sh = {rem_q, rad_q[sgd_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    geq    = rem_sh >= trial;
    rem_d  = geq ? RemW'(rem_sh - trial) : RemW'(rem_sh);
    root_d = {root_q[sgd_pkg::ROOT_W-2:0], geq};
    last   = busy_q && (step_q == sgd_pkg::STEP_W'(sgd_pkg::ROOT_STEPS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      step_q <= step_q + sgd_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[sgd_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  // done marks the cycle of the final step, root is valid the cycle after
  assign rsp_o.done = last;
  assign rsp_o.root = root_q;

endmodule
